// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/qdd_pkg.sv
// ----------------------------------------------------------------------------
// qdd_pkg
// Shared types, constants and the quadrature transition table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qdd_pkg;

  localparam int DefCountWidth = 8;

  // stream widths
  localparam int InDataWidth  = 16;
  localparam int OutDataWidth = 16;

  // configuration port
  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 5;

  localparam logic [CfgIndexWidth-1:0] REG_REV_DETENTS  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_CARD_SPACING = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_LATCH_STATE  = 2'd2;
  localparam logic [CfgIndexWidth-1:0] REG_WRAP_ENABLE  = 2'd3;

  localparam logic [4:0] RST_REV_DETENTS  = 5'd24;
  localparam logic [4:0] RST_CARD_SPACING = 5'd6;
  localparam logic [1:0] RST_LATCH_STATE  = 2'd3;
  localparam logic       RST_WRAP_ENABLE  = 1'b1;
  localparam logic [1:0] RST_PREV_PINS    = 2'd3;

  // action codes carried on tuser
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_SET    = 1'b1;

  localparam logic [5:0] NO_CARDINAL = 6'h3F;  // -1

  typedef struct packed {
    logic load;    // capture input beat
    logic update;  // apply beat to pin/count state
    logic step;    // advance cardinal walk
    logic emit;    // write result register
  } dp_cmd_t;

  typedef struct packed {
    logic done;    // walk resolved both on_cardinal and nearest
  } dp_status_t;

  // 4x decode: index {previous, current}, result -1/0/+1 as 2-bit signed
  function automatic logic [1:0] step_delta(input logic [3:0] idx);
    logic [1:0] d;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: d = 2'b11;
      4'd2, 4'd4, 4'd11, 4'd13: d = 2'b01;
      default: d = 2'b00;
    endcase
    return d;
  endfunction

endpackage

// File: sv/qdd_datapath.sv
// ----------------------------------------------------------------------------
// qdd_datapath
// Configuration registers, pin/count state, cardinal walk and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qdd_datapath #(
  parameter int COUNT_WIDTH = qdd_pkg::DefCountWidth
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [qdd_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [qdd_pkg::CfgDataWidth-1:0]  cfg_data,
  input  logic [qdd_pkg::InDataWidth-1:0]   s_tdata,
  input  logic                              s_tuser,
  input  qdd_pkg::dp_cmd_t                  cmd,
  output qdd_pkg::dp_status_t               status,
  output logic [qdd_pkg::OutDataWidth-1:0]  m_tdata
);
  import qdd_pkg::*;

  // configuration
  logic [4:0] rev_detents;
  logic [4:0] card_spacing;
  logic [1:0] latch_state;
  logic       wrap_enable;

  // captured beat
  logic       in_action;
  logic [1:0] in_pins;
  logic [5:0] in_new_position;
  logic [4:0] in_range;

  // decoder state
  logic [1:0]             prev_pins;
  logic [COUNT_WIDTH-1:0] fine_count;
  logic [5:0]             detent;
  logic                   changed;

  // walk state
  logic [6:0] idx;
  logic       card_hit;
  logic       near_found;
  logic [5:0] near_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      rev_detents  <= RST_REV_DETENTS;
      card_spacing <= RST_CARD_SPACING;
      latch_state  <= RST_LATCH_STATE;
      wrap_enable  <= RST_WRAP_ENABLE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REV_DETENTS:  rev_detents  <= cfg_data;
        REG_CARD_SPACING: card_spacing <= cfg_data;
        REG_LATCH_STATE:  latch_state  <= cfg_data[1:0];
        REG_WRAP_ENABLE:  wrap_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_action       <= s_tuser;
      in_pins         <= s_tdata[1:0];
      in_new_position <= s_tdata[7:2];
      in_range        <= s_tdata[12:8];
    end
  end

  // ---- state update ----
  logic [1:0]               now_pins;
  logic [COUNT_WIDTH+5:0]   np_wide;
  logic [COUNT_WIDTH-1:0]   fine_set;
  logic [1:0]               delta;
  logic [COUNT_WIDTH-1:0]   fine_add;
  logic [COUNT_WIDTH+3:0]   fine_wide;
  logic [5:0]               det_latch;
  logic [6:0]               det_ext;
  logic [6:0]               steps_ext;
  logic                     wrap_hit;

  assign now_pins  = in_pins;
  assign np_wide   = {{COUNT_WIDTH{in_new_position[5]}}, in_new_position};
  assign fine_set  = {np_wide[COUNT_WIDTH-3:0], fine_count[1:0]};
  assign delta     = step_delta({prev_pins, now_pins});
  assign fine_add  = fine_count + {{(COUNT_WIDTH-2){delta[1]}}, delta};
  assign fine_wide = {{4{fine_add[COUNT_WIDTH-1]}}, fine_add};
  assign det_latch = (now_pins == latch_state) ? fine_wide[7:2] : detent;
  assign det_ext   = {det_latch[5], det_latch};
  assign steps_ext = {2'b00, rev_detents};
  assign wrap_hit  = wrap_enable && (det_ext == steps_ext || det_ext == 7'(-steps_ext));

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pins  <= RST_PREV_PINS;
      fine_count <= '0;
      detent     <= '0;
    end else if (cmd.update) begin
      if (in_action == ACT_SET) begin
        fine_count <= fine_set;
        detent     <= in_new_position;
      end else if (now_pins != prev_pins) begin
        prev_pins <= now_pins;
        if (wrap_hit) begin
          fine_count <= '0;
          detent     <= '0;
        end else begin
          fine_count <= fine_add;
          detent     <= det_latch;
        end
      end
    end
  end

  // ---- cardinal walk: one candidate point per cycle ----
  logic [5:0] abs_pos;
  logic [7:0] pos_ext;
  logic [7:0] rel;
  logic [8:0] diff;
  logic [8:0] abs_diff;
  logic       near_now;
  logic       cur_card;
  logic       cur_found;
  logic [5:0] cur_val;
  logic [7:0] idx_next;
  logic       stride_zero;

  assign abs_pos     = detent[5] ? 6'(-detent) : detent;
  assign pos_ext     = {{2{detent[5]}}, detent};
  assign rel         = detent[5] ? pos_ext + {3'b000, rev_detents} : pos_ext;
  assign diff        = {rel[7], rel} - {2'b00, idx};
  assign abs_diff    = diff[8] ? 9'(-diff) : diff;
  assign near_now    = !near_found && (idx <= {2'b00, rev_detents})
                       && (abs_diff <= {4'b0000, in_range});
  assign cur_card    = card_hit || (idx == {1'b0, abs_pos});
  assign cur_found   = near_found || near_now;
  assign cur_val     = near_found ? near_val :
                       ((idx == {2'b00, rev_detents}) ? 6'd0 : idx[5:0]);
  assign idx_next    = {1'b0, idx} + {3'b000, card_spacing};
  assign stride_zero = (card_spacing == 5'd0);

  assign status.done = (cur_found || stride_zero || idx_next > {3'b000, rev_detents})
                    && (cur_card || stride_zero || idx_next > {2'b00, abs_pos});

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      idx        <= '0;
      card_hit   <= 1'b0;
      near_found <= 1'b0;
      changed    <= (in_action == ACT_SAMPLE) && (now_pins != prev_pins);
    end else if (cmd.step) begin
      idx        <= idx_next[6:0];
      card_hit   <= cur_card;
      near_found <= cur_found;
      near_val   <= cur_val;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {2'b00, (cur_found ? cur_val : NO_CARDINAL), cur_card, detent, changed};
    end
  end

endmodule

// File: sv/qdd_ctrl.sv
// ----------------------------------------------------------------------------
// qdd_ctrl
// Sequencer: capture beat, update state, walk cardinal points, emit result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qdd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  qdd_pkg::dp_status_t status,
  output qdd_pkg::dp_cmd_t    cmd
);
  import qdd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SEARCH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (!status.done) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/quadrature_decoder_with_detents_top.sv
// Quadrature decoder with detents. Each input beat either samples the two
// encoder pins (4x decode into a signed fine count, detent position updated
// when the pins reach the latch state, optional wrap at plus or minus the
// detents per revolution) or loads a detent position, and yields exactly one
// result beat carrying the change flag, the detent position, whether it sits
// on a cardinal point and the nearest cardinal point within the requested
// range (-1 if none). After the beat is captured and the state updated, the
// walk unit visits the cardinal points 0, s, 2s and so on, one per cycle,
// until both cardinal answers are settled; the result register then loads
// once the output is free, and the next beat is taken in the cycle after
// that. A new beat is taken once the result is registered, even while it
// waits on m_tready.
`timescale 1ns / 1ps

`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// quadrature_decoder_with_detents_top
// Stream wrapper joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
module quadrature_decoder_with_detents_top #(
  parameter int COUNT_WIDTH = qdd_pkg::DefCountWidth
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [qdd_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [qdd_pkg::CfgDataWidth-1:0]  cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [0] pin_a, [1] pin_b, [7:2] new_position, [12:8] cardinal_range
  input  logic [qdd_pkg::InDataWidth-1:0]   s_tdata,
  // [0] action
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] changed, [6:1] position, [7] on_cardinal, [13:8] nearest_cardinal
  output logic [qdd_pkg::OutDataWidth-1:0]  m_tdata
);
  import qdd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  qdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  qdd_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .status    (status),
    .m_tdata   (m_tdata)
  );

  `ASSERT_SAME(a_load_on_beat, clk, rst, cmd.load, s_tvalid && s_tready)
  `ASSERT_SAME(a_emit_when_free, clk, rst, cmd.emit, !m_tvalid || m_tready)
  `ASSERT_NEXT(a_emit_valid, clk, rst, cmd.emit, m_tvalid)
  `ASSERT_SAME(a_step_not_done, clk, rst, cmd.step, !status.done && !cmd.emit)

endmodule

// File: test/quadrature_decoder_with_detents_top_tb.sv
// ----------------------------------------------------------------------------
// quadrature_decoder_with_detents_top_tb
// Drives pin samples and position loads into the decoder and checks every
// result beat against a cycle-free model of the count, latch, wrap and
// cardinal logic. A directed table runs first, then random rotation traffic
// over several register settings and handshake idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quadrature_decoder_with_detents_top_tb;
  import qdd_pkg::*;

  localparam int CycleLimit    = 600000;
  localparam int PhaseCount    = 8;
  localparam int ItemsPerPhase = 92;
  localparam int HoldCycles    = 300;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic              action;
    logic              pin_a;
    logic              pin_b;
    logic signed [5:0] new_pos;
    logic [4:0]        card_range;
  } pin_item_t;

  typedef struct {
    logic              changed;
    logic signed [5:0] position;
    logic              on_card;
    logic signed [5:0] nearest;
  } detent_result_t;

  typedef struct {
    pin_item_t      stim;
    bit             typed;
    detent_result_t want;
  } table_row_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data = '0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [InDataWidth-1:0]   s_tdata = '0;
  logic                     s_tuser = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OutDataWidth-1:0]  m_tdata;

  quadrature_decoder_with_detents_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // decoder state mirror
  logic [4:0]        cfg_steps = RST_REV_DETENTS;
  logic [4:0]        cfg_card  = RST_CARD_SPACING;
  logic [1:0]        cfg_latch = RST_LATCH_STATE;
  logic              cfg_wrap  = RST_WRAP_ENABLE;
  logic [1:0]        pins_q    = RST_PREV_PINS;
  logic [7:0]        fine_q    = '0;
  logic signed [5:0] detent_q  = '0;

  // 4x decode, indexed by {previous, current}
  int turn_dir [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

  detent_result_t pending_results[$];
  table_row_t     dir_rows[$];
  idle_mode_t     idle_mode = IDLE_NONE;
  int             mismatches = 0;
  int             cycles = 0;
  int             spin_dir = 1;
  int             hold_seq = 0;
  int             hold_seen = 0;
  int             hold_left = 0;

  int ph_steps [PhaseCount] = '{24, 31, 1, 5, 12, 0, 31, 7};
  int ph_card  [PhaseCount] = '{6, 31, 1, 3, 4, 0, 1, 0};
  int ph_latch [PhaseCount] = '{3, 0, 1, 2, 3, 3, 3, 1};
  int ph_wrap  [PhaseCount] = '{1, 1, 1, 0, 1, 1, 1, 1};
  idle_mode_t ph_mode [PhaseCount] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                       IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Advance the mirrored state by one item and return its result.
  function automatic detent_result_t decode_item(input pin_item_t it);
    detent_result_t r;
    logic [1:0] now;
    int delta, pos, steps, stride, rel, i, d, hit;
    bit found;
    r.changed = 1'b0;
    if (it.action == ACT_SET) begin
      fine_q   = {it.new_pos, fine_q[1:0]};
      detent_q = it.new_pos;
    end else begin
      now = {it.pin_b, it.pin_a};
      if (now != pins_q) begin
        delta  = turn_dir[{pins_q, now}];
        fine_q = fine_q + delta[7:0];
        if (now == cfg_latch) detent_q = fine_q[7:2];
        pos   = int'(detent_q);
        steps = int'(cfg_steps);
        if (cfg_wrap && (pos == steps || pos == -steps)) begin
          fine_q   = '0;
          detent_q = '0;
        end
        pins_q    = now;
        r.changed = 1'b1;
      end
    end
    pos    = int'(detent_q);
    steps  = int'(cfg_steps);
    stride = int'(cfg_card);
    if (stride == 0) r.on_card = (pos == 0);
    else r.on_card = ((pos % stride) == 0);
    // walk cardinal points 0, s, 2s, ... up to one revolution
    rel   = (pos < 0) ? pos + steps : pos;
    hit   = -1;
    found = 0;
    i     = 0;
    while (!found && i <= steps) begin
      d = rel - i;
      if (d < 0) d = -d;
      if (d <= int'(it.card_range)) begin
        found = 1;
        hit   = (i == steps) ? 0 : i;
      end else if (stride == 0) begin
        i = steps + 1;
      end else begin
        i = i + stride;
      end
    end
    r.position = detent_q;
    r.nearest  = hit[5:0];
    return r;
  endfunction

  // Mostly clean rotation in runs, with repeats, double flips and loads.
  function automatic pin_item_t next_motion();
    pin_item_t it;
    logic [1:0] nxt;
    int pick, np;
    pick          = $urandom_range(99);
    np            = $urandom_range(63);
    it.action     = ACT_SAMPLE;
    it.new_pos    = np[5:0];
    it.card_range = 5'($urandom_range(31));
    nxt           = pins_q;
    if (pick < 4) spin_dir = -spin_dir;
    if (pick < 8) begin
      nxt = pins_q;
    end else if (pick < 12) begin
      nxt = ~pins_q;
    end else if (pick < 25) begin
      it.action = ACT_SET;
      nxt = 2'($urandom_range(3));
      if ($urandom_range(1)) begin
        np = (int'(cfg_steps) - int'($urandom_range(2))) * (($urandom_range(1)) ? 1 : -1);
        if (np > 31) np = 31;
        if (np < -32) np = -32;
        it.new_pos = np[5:0];
      end
    end else if (spin_dir > 0) begin
      case (pins_q)
        2'd3: nxt = 2'd1;
        2'd1: nxt = 2'd0;
        2'd0: nxt = 2'd2;
        default: nxt = 2'd3;
      endcase
    end else begin
      case (pins_q)
        2'd3: nxt = 2'd2;
        2'd2: nxt = 2'd0;
        2'd0: nxt = 2'd1;
        default: nxt = 2'd3;
      endcase
    end
    it.pin_a = nxt[0];
    it.pin_b = nxt[1];
    return it;
  endfunction

  task automatic add_row(input logic act, input logic a, input logic b, input int np,
                         input int rng, input bit typed = 0, input int w_pos = 0,
                         input logic w_oc = 0, input logic [5:0] w_nc = 0);
    table_row_t row;
    row.stim.action     = act;
    row.stim.pin_a      = a;
    row.stim.pin_b      = b;
    row.stim.new_pos    = np[5:0];
    row.stim.card_range = rng[4:0];
    row.typed           = typed;
    row.want.changed    = 1'b0;
    row.want.position   = w_pos[5:0];
    row.want.on_card    = w_oc;
    row.want.nearest    = w_nc;
    dir_rows.push_back(row);
  endtask

  task automatic send_beat(input pin_item_t it, input bit typed, input detent_result_t want);
    detent_result_t predicted;
    int idle_pct;
    idle_pct = (idle_mode == IDLE_SEND) ? 78 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.action;
    s_tdata  <= {3'b000, it.card_range, it.new_pos, it.pin_b, it.pin_a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = decode_item(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[4:0];
    case (idx)
      REG_REV_DETENTS:  cfg_steps = val[4:0];
      REG_CARD_SPACING: cfg_card  = val[4:0];
      REG_LATCH_STATE:  cfg_latch = val[1:0];
      REG_WRAP_ENABLE:  cfg_wrap  = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (idle_mode == IDLE_RECV) begin
      m_tready <= ($urandom_range(99) >= 78);
    end else if (idle_mode == IDLE_BOTH) begin
      m_tready <= ($urandom_range(99) >= 11);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    detent_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.changed  = m_tdata[0];
      got.position = m_tdata[6:1];
      got.on_card  = m_tdata[7];
      got.nearest  = m_tdata[13:8];
      if (pending_results.size() == 0) begin
        $error("result beat with no result pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.changed !== want.changed) begin
          $error("changed: expected %0d, got %0d", want.changed, got.changed);
          mismatches++;
        end
        if (got.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, got.position);
          mismatches++;
        end
        if (got.on_card !== want.on_card) begin
          $error("on_cardinal: expected %0d, got %0d", want.on_card, got.on_card);
          mismatches++;
        end
        if (got.nearest !== want.nearest) begin
          $error("nearest_cardinal: expected %0d, got %0d", want.nearest, got.nearest);
          mismatches++;
        end
      end
    end
  end

  initial begin
    detent_result_t none;
    none = '{1'b0, 6'sd0, 1'b0, 6'sd0};

    // reset-value checks and extremes of the load path
    add_row(ACT_SAMPLE, 1, 1, 0, 0, 1, 0, 1'b1, 6'd0);
    add_row(ACT_SET, 0, 0, 31, 0, 1, 31, 1'b0, NO_CARDINAL);
    add_row(ACT_SET, 1, 1, -32, 31, 1, -32, 1'b0, 6'd0);
    add_row(ACT_SET, 0, 1, 0, 0, 1, 0, 1'b1, 6'd0);
    // one detent forward, then back
    add_row(ACT_SAMPLE, 1, 0, -17, 2);
    add_row(ACT_SAMPLE, 0, 0, 5, 31);
    add_row(ACT_SAMPLE, 0, 1, 0, 5);
    add_row(ACT_SAMPLE, 1, 1, 0, 1);
    add_row(ACT_SAMPLE, 0, 1, 0, 3);
    add_row(ACT_SAMPLE, 0, 0, 0, 0);
    add_row(ACT_SAMPLE, 1, 0, 0, 7);
    add_row(ACT_SAMPLE, 1, 1, 0, 4);
    // both pins flip: no count, but latch still runs
    add_row(ACT_SAMPLE, 0, 0, 0, 6);
    add_row(ACT_SAMPLE, 1, 1, 0, 9);
    // wrap at +steps
    add_row(ACT_SET, 1, 0, 23, 2);
    add_row(ACT_SAMPLE, 1, 0, 0, 0);
    add_row(ACT_SAMPLE, 0, 0, 0, 31);
    add_row(ACT_SAMPLE, 0, 1, 0, 1);
    add_row(ACT_SAMPLE, 1, 1, 0, 2);
    // wrap at -steps
    add_row(ACT_SET, 0, 1, -23, 3);
    add_row(ACT_SAMPLE, 0, 1, 0, 2);
    add_row(ACT_SAMPLE, 0, 0, 0, 0);
    add_row(ACT_SAMPLE, 1, 0, 0, 5);
    add_row(ACT_SAMPLE, 1, 1, 0, 31);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) send_beat(dir_rows[k].stim, dir_rows[k].typed, dir_rows[k].want);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      if (ph != 0) begin
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        write_reg(REG_REV_DETENTS, ph_steps[ph]);
        write_reg(REG_CARD_SPACING, ph_card[ph]);
        write_reg(REG_LATCH_STATE, ph_latch[ph]);
        write_reg(REG_WRAP_ENABLE, ph_wrap[ph]);
        cfg_we <= 1'b0;
      end
      idle_mode = ph_mode[ph];
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (ph == 4 && n == 10) hold_seq = hold_seq + 1;
        send_beat(next_motion(), 1'b0, none);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/qdd_pkg.sv
sv/qdd_datapath.sv
sv/qdd_ctrl.sv
sv/quadrature_decoder_with_detents_top.sv
test/quadrature_decoder_with_detents_top_tb.sv
